// File: hdl/lidar_frame_point_parser_macros.svh
// ----------------------------------------------------------------------------
// Lidar frame point parser assertion macros
// Shorthand for clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef LIDAR_FRAME_POINT_PARSER_MACROS_SVH
`define LIDAR_FRAME_POINT_PARSER_MACROS_SVH

// Same-cycle implication.
`define LFPP_ASSERT_NOW(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("lfpp check failed");

// Next-cycle implication.
`define LFPP_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("lfpp check failed");

`endif

// File: hdl/lfpp_pkg.sv
// ----------------------------------------------------------------------------
// Lidar frame point parser package
// Types, codes and constants shared by the parser modules.
// ----------------------------------------------------------------------------
package lfpp_pkg;

    localparam logic [7:0] SOF_BYTE   = 8'hAA;
    localparam logic [7:0] TYPE_BYTE  = 8'h61;
    localparam logic [7:0] CMD_DATA   = 8'hAD;
    localparam logic [7:0] CMD_HEALTH = 8'hAE;

    localparam logic [11:0] ANGLE_SPAN   = 12'd2250;
    localparam int          DIV_STEPS    = 12;
    localparam logic [16:0] DIV3_RECIP   = 17'd43691;   // ceil(2^17 / 3)
    localparam logic [15:0] DLEN_MIN     = 16'd8;
    localparam logic [15:0] DLEN_HDR     = 16'd5;

    localparam logic [1:0] KIND_POINT      = 2'd0;
    localparam logic [1:0] KIND_DATA_END   = 2'd1;
    localparam logic [1:0] KIND_HEALTH_END = 2'd2;

    localparam logic [2:0] REG_BIG_ENDIAN = 3'd0;

    typedef enum logic [3:0] {
        PH_START,
        PH_FLEN,
        PH_VER,
        PH_TYPE,
        PH_CMD,
        PH_DLEN,
        PH_DIV,
        PH_DATA,
        PH_HEALTH,
        PH_CSUM
    } lfpp_phase_t;

    typedef enum logic [2:0] {
        DP_SPEED,
        DP_OFFSET,
        DP_START,
        DP_STRENGTH,
        DP_DIST
    } lfpp_dphase_t;

    typedef struct packed {
        logic take;
        logic sum_add;
        logic resync;
        logic hw_step;
        logic hw_clr;
        logic set_kind;
        logic kind_data;
        logic ld_dlen;
        logic ld_count;
        logic clr_seen;
        logic inc_seen;
        logic ld_speed;
        logic ld_angle;
        logic ld_strength;
        logic emit_point;
        logic emit_end;
    } lfpp_cmd_t;

    typedef struct packed {
        logic is_sof;
        logic is_type;
        logic is_cmd_data;
        logic is_cmd_health;
        logic hw_pending;
        logic is_data;
        logic dlen_short;
        logic last_byte;
        logic div_busy;
        logic out_free;
    } lfpp_stat_t;

endpackage

// File: hdl/lfpp_in_if.sv
// ----------------------------------------------------------------------------
// Lidar frame point parser input channel
// Valid/ready channel carrying one received serial byte.
// ----------------------------------------------------------------------------
interface lfpp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

// File: hdl/lfpp_out_if.sv
// ----------------------------------------------------------------------------
// Lidar frame point parser output channel
// Valid/ready channel carrying one point or frame-end result.
// ----------------------------------------------------------------------------
interface lfpp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [7:0]  strength;
    logic [15:0] distance_raw;
    logic [16:0] angle_centideg;
    logic [7:0]  speed_raw;
    logic        checksum_ok;

    modport source (output valid, output result_kind, output strength,
                    output distance_raw, output angle_centideg, output speed_raw,
                    output checksum_ok, input ready);
    modport sink (input valid, input result_kind, input strength,
                  input distance_raw, input angle_centideg, input speed_raw,
                  input checksum_ok, output ready);
endinterface

// File: hdl/lfpp_ctrl.sv
// ----------------------------------------------------------------------------
// Lidar frame point parser controller
// Frame and data-field state machines; issues datapath commands per byte.
// ----------------------------------------------------------------------------
module lfpp_ctrl
    import lfpp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  lfpp_stat_t stat,
    output lfpp_cmd_t  cmd
);

    lfpp_phase_t  phase_reg, phase_next;
    lfpp_dphase_t dphase_reg, dphase_next;
    logic         take;

    assign in_ready = stat.out_free && (phase_reg != PH_DIV);
    assign take     = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_START;
            dphase_reg <= DP_SPEED;
        end
        else
        begin
            phase_reg  <= phase_next;
            dphase_reg <= dphase_next;
        end
    end

    // Next state
    always_comb
    begin
        phase_next  = phase_reg;
        dphase_next = dphase_reg;
        if (phase_reg == PH_DIV)
        begin
            if (!stat.div_busy)
                phase_next = PH_DATA;
        end
        else if (take)
        begin
            unique case (phase_reg)
                PH_START:  if (stat.is_sof) phase_next = PH_FLEN;
                PH_FLEN:   if (stat.hw_pending) phase_next = PH_VER;
                PH_VER:    phase_next = PH_TYPE;
                PH_TYPE:   phase_next = stat.is_type ? PH_CMD : PH_START;
                PH_CMD:
                begin
                    if (stat.is_cmd_data || stat.is_cmd_health)
                        phase_next = PH_DLEN;
                    else
                        phase_next = PH_START;
                end
                PH_DLEN:
                begin
                    if (stat.hw_pending)
                    begin
                        if (!stat.is_data)
                            phase_next = PH_HEALTH;
                        else if (stat.dlen_short)
                            phase_next = PH_START;
                        else
                        begin
                            phase_next  = PH_DIV;
                            dphase_next = DP_SPEED;
                        end
                    end
                end
                PH_DATA:
                begin
                    unique case (dphase_reg)
                        DP_SPEED:    dphase_next = DP_OFFSET;
                        DP_OFFSET:   if (stat.hw_pending) dphase_next = DP_START;
                        DP_START:    if (stat.hw_pending) dphase_next = DP_STRENGTH;
                        DP_STRENGTH: dphase_next = DP_DIST;
                        DP_DIST:     if (stat.hw_pending) dphase_next = DP_STRENGTH;
                        default:     dphase_next = DP_DIST;
                    endcase
                    if (stat.last_byte)
                        phase_next = PH_CSUM;
                end
                PH_HEALTH: phase_next = PH_CSUM;
                PH_CSUM:   if (stat.hw_pending) phase_next = PH_START;
                default:   phase_next = PH_START;
            endcase
        end
    end

    // Commands
    always_comb
    begin
        cmd      = '0;
        cmd.take = take;
        if (take)
        begin
            cmd.sum_add = (phase_reg != PH_CSUM);
            unique case (phase_reg)
                PH_START: cmd.resync = !stat.is_sof;
                PH_FLEN:  cmd.hw_step = 1'b1;
                PH_VER:   cmd.hw_step = 1'b0;
                PH_TYPE:  cmd.resync = !stat.is_type;
                PH_CMD:
                begin
                    cmd.set_kind  = stat.is_cmd_data || stat.is_cmd_health;
                    cmd.kind_data = stat.is_cmd_data;
                    cmd.resync    = !(stat.is_cmd_data || stat.is_cmd_health);
                end
                PH_DLEN:
                begin
                    cmd.hw_step = 1'b1;
                    if (stat.hw_pending)
                    begin
                        cmd.ld_dlen = 1'b1;
                        if (stat.is_data)
                        begin
                            cmd.resync   = stat.dlen_short;
                            cmd.ld_count = !stat.dlen_short;
                            cmd.clr_seen = !stat.dlen_short;
                        end
                    end
                end
                PH_DATA:
                begin
                    cmd.inc_seen = 1'b1;
                    unique case (dphase_reg)
                        DP_SPEED:  cmd.ld_speed = 1'b1;
                        DP_OFFSET: cmd.hw_step = 1'b1;
                        DP_START:
                        begin
                            cmd.hw_step  = 1'b1;
                            cmd.ld_angle = stat.hw_pending;
                        end
                        DP_DIST:
                        begin
                            cmd.hw_step    = 1'b1;
                            cmd.emit_point = stat.hw_pending;
                        end
                        default:   cmd.ld_strength = 1'b1;
                    endcase
                    cmd.hw_clr = stat.last_byte;
                end
                PH_HEALTH: cmd.ld_speed = 1'b1;
                PH_CSUM:
                begin
                    cmd.hw_step  = 1'b1;
                    cmd.emit_end = stat.hw_pending;
                    cmd.resync   = stat.hw_pending;
                end
                default:  cmd.resync = 1'b1;
            endcase
        end
    end

endmodule

// File: hdl/lfpp_dp.sv
// ----------------------------------------------------------------------------
// Lidar frame point parser datapath
// Field assembly, byte sum, angle step divider and the result register.
// ----------------------------------------------------------------------------
module lfpp_dp
    import lfpp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        big_endian,
    input  logic [7:0]  rx_byte,
    input  lfpp_cmd_t   cmd,
    output lfpp_stat_t  stat,
    input  logic        out_ready,
    output logic        out_valid,
    output logic [1:0]  out_kind,
    output logic [7:0]  out_strength,
    output logic [15:0] out_distance,
    output logic [16:0] out_angle,
    output logic [7:0]  out_speed,
    output logic        out_ok
);

    logic        hw_pending_reg;
    logic [7:0]  low_hold_reg;
    logic [15:0] dlen_reg;
    logic        is_data_reg;
    logic [15:0] sum_reg;
    logic [15:0] seen_reg;
    logic [7:0]  speed_reg;
    logic [16:0] angle_reg;
    logic [15:0] count_reg;
    logic [7:0]  strength_reg;
    logic [15:0] rem_acc_reg;
    logic [11:0] quot_reg;
    logic [15:0] rem_reg;
    logic [3:0]  div_cnt_reg;
    logic        div_busy_reg;
    logic        out_valid_reg;
    logic [1:0]  kind_reg;
    logic [7:0]  ostr_reg;
    logic [15:0] odist_reg;
    logic [16:0] oang_reg;
    logic [7:0]  ospd_reg;
    logic        ook_reg;

    logic [15:0] word;
    logic [15:0] sum_next;
    logic [15:0] seen_inc;
    logic [15:0] dlen_m5;
    logic [32:0] div3_prod;
    logic [16:0] trial;
    logic [16:0] rem_sum;
    logic [16:0] angle_step;
    logic        rem_wrap;

    assign word     = big_endian ? {low_hold_reg, rx_byte} : {rx_byte, low_hold_reg};
    assign sum_next = sum_reg + {8'd0, rx_byte};
    assign seen_inc = seen_reg + 16'd1;
    assign dlen_m5  = word - DLEN_HDR;
    assign div3_prod = {17'd0, dlen_m5} * {16'd0, DIV3_RECIP};
    assign trial    = {rem_reg, ANGLE_SPAN[div_cnt_reg - 4'd1]};
    assign rem_sum  = {1'b0, rem_acc_reg} + {1'b0, rem_reg};
    assign rem_wrap = (rem_sum >= {1'b0, count_reg});
    assign angle_step = angle_reg + {5'd0, quot_reg} + {16'd0, rem_wrap};

    always_comb
    begin
        stat.is_sof        = (rx_byte == SOF_BYTE);
        stat.is_type       = (rx_byte == TYPE_BYTE);
        stat.is_cmd_data   = (rx_byte == CMD_DATA);
        stat.is_cmd_health = (rx_byte == CMD_HEALTH);
        stat.hw_pending    = hw_pending_reg;
        stat.is_data       = is_data_reg;
        stat.dlen_short    = (word < DLEN_MIN);
        stat.last_byte     = (seen_inc == dlen_reg);
        stat.div_busy      = div_busy_reg;
        stat.out_free      = !out_valid_reg || out_ready;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hw_pending_reg <= 1'b0;
            sum_reg        <= '0;
            div_busy_reg   <= 1'b0;
            div_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.resync || cmd.hw_clr)
                hw_pending_reg <= 1'b0;
            else if (cmd.hw_step)
                hw_pending_reg <= !hw_pending_reg;

            if (cmd.resync)
                sum_reg <= '0;
            else if (cmd.sum_add)
                sum_reg <= sum_next;

            if (cmd.ld_count)
            begin
                div_busy_reg <= 1'b1;
                div_cnt_reg  <= 4'(DIV_STEPS);
            end
            else if (div_busy_reg)
            begin
                div_cnt_reg  <= div_cnt_reg - 4'd1;
                div_busy_reg <= (div_cnt_reg != 4'd1);
            end

            if (cmd.emit_point || cmd.emit_end)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (cmd.hw_step && !hw_pending_reg)
            low_hold_reg <= rx_byte;
        if (cmd.set_kind)
            is_data_reg <= cmd.kind_data;
        if (cmd.ld_dlen)
            dlen_reg <= word;
        if (cmd.clr_seen)
            seen_reg <= '0;
        else if (cmd.inc_seen)
            seen_reg <= seen_inc;
        if (cmd.ld_speed)
            speed_reg <= rx_byte;
        if (cmd.ld_strength)
            strength_reg <= rx_byte;

        if (cmd.ld_count)
        begin
            count_reg <= div3_prod[32:17];
            rem_reg   <= '0;
            quot_reg  <= '0;
        end
        else if (div_busy_reg)
        begin
            if (trial >= {1'b0, count_reg})
            begin
                rem_reg  <= 16'(trial - {1'b0, count_reg});
                quot_reg <= {quot_reg[10:0], 1'b1};
            end
            else
            begin
                rem_reg  <= trial[15:0];
                quot_reg <= {quot_reg[10:0], 1'b0};
            end
        end

        if (cmd.ld_angle)
        begin
            angle_reg   <= {1'b0, word};
            rem_acc_reg <= '0;
        end
        else if (cmd.emit_point)
        begin
            angle_reg   <= angle_step;
            rem_acc_reg <= rem_wrap ? 16'(rem_sum - {1'b0, count_reg}) : rem_sum[15:0];
        end

        if (cmd.emit_point)
        begin
            kind_reg  <= KIND_POINT;
            ostr_reg  <= strength_reg;
            odist_reg <= word;
            oang_reg  <= angle_reg;
            ospd_reg  <= speed_reg;
            ook_reg   <= 1'b0;
        end
        else if (cmd.emit_end)
        begin
            kind_reg  <= is_data_reg ? KIND_DATA_END : KIND_HEALTH_END;
            ostr_reg  <= '0;
            odist_reg <= '0;
            oang_reg  <= '0;
            ospd_reg  <= speed_reg;
            ook_reg   <= (sum_reg == word);
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_kind     = kind_reg;
    assign out_strength = ostr_reg;
    assign out_distance = odist_reg;
    assign out_angle    = oang_reg;
    assign out_speed    = ospd_reg;
    assign out_ok       = ook_reg;

endmodule

// File: hdl/lidar_frame_point_parser.sv
// ----------------------------------------------------------------------------
// Lidar frame point parser
// Parses the lidar serial stream into measurement points and frame-end
// results, with an APB register for the byte order of 16-bit fields.
// ----------------------------------------------------------------------------
// One byte is taken per cycle whenever the result register is free and no
// divide is in progress. After the data length of a data frame the block
// computes the per-point angle step 2250/n in a restoring divider, one
// quotient bit per cycle: input ready stays low through the 12 divider
// steps and the hand-back to the data phase. The result register
// decouples the two sides; apart from the divider, input ready drops only
// while a result waits and is not being taken. Register 0 at byte address 0
// (bit 0) selects high byte first for all 16-bit fields, checksum included;
// write it only idle.
module lidar_frame_point_parser
    import lfpp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    lfpp_in_if.sink     in_ch,
    lfpp_out_if.source  out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    lfpp_cmd_t  cmd;
    lfpp_stat_t stat;
    logic       big_endian_reg;
    logic       in_valid;
    logic       in_ready;
    logic       out_valid;
    logic       out_ready;
    logic [1:0] result_kind;

    // Mirror the channel handshakes locally.
    assign in_valid  = in_ch.valid;
    assign in_ch.ready = in_ready;
    assign out_ready = out_ch.ready;
    assign out_ch.valid = out_valid;
    assign out_ch.result_kind = result_kind;

    // Config register: write in the access phase, zero-wait.
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            big_endian_reg <= 1'b0;
        else if (psel && penable && pwrite && (paddr == REG_BIG_ENDIAN))
            big_endian_reg <= pwdata[0];
    end

    always_comb
    begin
        unique case (paddr)
            REG_BIG_ENDIAN: prdata = {31'd0, big_endian_reg};
            default:        prdata = '0;
        endcase
    end

    // Sequencer: decide per byte what the datapath does.
    lfpp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Datapath: assemble fields, divide, accumulate angle, hold the result.
    lfpp_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .big_endian   (big_endian_reg),
        .rx_byte      (in_ch.rx_byte),
        .cmd          (cmd),
        .stat         (stat),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .out_kind     (result_kind),
        .out_strength (out_ch.strength),
        .out_distance (out_ch.distance_raw),
        .out_angle    (out_ch.angle_centideg),
        .out_speed    (out_ch.speed_raw),
        .out_ok       (out_ch.checksum_ok)
    );

endmodule

// File: hdl/lfpp_chk.sv
// ----------------------------------------------------------------------------
// Lidar frame point parser checker
// Port-level assertions, bound to the parser top level.
// ----------------------------------------------------------------------------
`include "lidar_frame_point_parser_macros.svh"

module lfpp_chk
    import lfpp_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] result_kind
);

    `LFPP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    `LFPP_ASSERT_NOW(a_no_take_stalled, clk, rst_n, out_valid && !out_ready, !in_ready)
    `LFPP_ASSERT_NOW(a_kind_legal, clk, rst_n, out_valid, result_kind != 2'd3)
    `LFPP_ASSERT_NEXT(a_one_result, clk, rst_n, out_valid && out_ready && !in_ready, !out_valid)

endmodule

bind lidar_frame_point_parser lfpp_chk u_lfpp_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .result_kind (result_kind)
);
